// ===== hw/rtl/jte_pkg.sv =====
package jte_pkg;

  localparam int JOB_SLOTS = 16;
  localparam int SLOT_W    = $clog2(JOB_SLOTS);
  localparam int OP_W      = 3;
  localparam int PID_W     = 22;
  localparam int JID_W     = 5;
  localparam int ST_W      = 2;
  localparam int TDATA_W   = 32;

  localparam logic [ST_W-1:0]  STATE_UNDEF = 2'd0;
  localparam logic [ST_W-1:0]  STATE_FG    = 2'd1;
  localparam logic [JID_W-1:0] JID_MAX     = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 3'd0,
    OP_DEL_PID  = 3'd1,
    OP_FIND_PID = 3'd2,
    OP_FIND_JID = 3'd3,
    OP_SET_PID  = 3'd4,
    OP_SET_JID  = 3'd5,
    OP_FIND_FG  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAX,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic apply;
    logic max_step;
    logic max_done;
    logic emit;
  } jte_cmd_t;

  typedef struct packed {
    logic key_ok;
    logic match;
    logic last;
    logic is_del;
  } jte_stat_t;

endpackage

// ===== hw/rtl/jte_datapath.sv =====
module jte_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jte_pkg::jte_cmd_t          cmd_i,
  output jte_pkg::jte_stat_t         stat_o,
  input  logic [jte_pkg::OP_W-1:0]   in_op_i,
  input  logic [jte_pkg::PID_W-1:0]  in_pid_i,
  input  logic [jte_pkg::JID_W-1:0]  in_jid_i,
  input  logic [jte_pkg::ST_W-1:0]   in_st_i,
  output logic                       out_hit_o,
  output logic [jte_pkg::PID_W-1:0]  out_pid_o,
  output logic [jte_pkg::JID_W-1:0]  out_jid_o,
  output logic [jte_pkg::ST_W-1:0]   out_st_o
);
  import jte_pkg::*;

  logic [PID_W-1:0]  slot_pid_q [JOB_SLOTS];
  logic [JID_W-1:0]  slot_jid_q [JOB_SLOTS];
  logic [ST_W-1:0]   slot_st_q  [JOB_SLOTS];
  logic [JID_W-1:0]  next_q;
  logic [SLOT_W-1:0] idx_q;
  logic [JID_W-1:0]  mx_q;

  logic [OP_W-1:0]   op_q;
  logic [PID_W-1:0]  key_pid_q;
  logic [JID_W-1:0]  key_jid_q;
  logic [ST_W-1:0]   key_st_q;

  logic              res_hit_q;
  logic [PID_W-1:0]  res_pid_q;
  logic [JID_W-1:0]  res_jid_q;
  logic [ST_W-1:0]   res_st_q;

  logic              out_hit_q;
  logic [PID_W-1:0]  out_pid_q;
  logic [JID_W-1:0]  out_jid_q;
  logic [ST_W-1:0]   out_st_q;

  logic [PID_W-1:0]  rd_pid;
  logic [JID_W-1:0]  rd_jid;
  logic [ST_W-1:0]   rd_st;
  logic              key_ok;
  logic              match;
  logic [JID_W:0]    add_nxt;
  logic [JID_W-1:0]  add_next_d;
  logic [JID_W-1:0]  mx_d;
  logic [JID_W:0]    mx_inc;
  logic [JID_W-1:0]  del_next_d;

  assign rd_pid = slot_pid_q[idx_q];
  assign rd_jid = slot_jid_q[idx_q];
  assign rd_st  = slot_st_q[idx_q];

  always_comb begin
    key_ok = 1'b0;
    match  = 1'b0;
    unique case (op_q) inside
      OP_ADD: begin
        key_ok = (key_pid_q != '0);
        match  = (rd_pid == '0);
      end
      OP_DEL_PID, OP_FIND_PID, OP_SET_PID: begin
        key_ok = (key_pid_q != '0);
        match  = (rd_pid == key_pid_q);
      end
      OP_FIND_JID, OP_SET_JID: begin
        key_ok = (key_jid_q != '0);
        match  = (rd_jid == key_jid_q);
      end
      OP_FIND_FG: begin
        key_ok = 1'b1;
        match  = (rd_st == STATE_FG);
      end
      default: begin
        key_ok = 1'b0;
        match  = 1'b0;
      end
    endcase
  end

  assign stat_o.key_ok = key_ok;
  assign stat_o.match  = match;
  assign stat_o.last   = (idx_q == SLOT_W'(JOB_SLOTS - 1));
  assign stat_o.is_del = (op_q == OP_DEL_PID);

  // add: wrap to 1 past the slot count
  assign add_nxt    = {1'b0, next_q} + (JID_W+1)'(1);
  assign add_next_d = (add_nxt > (JID_W+1)'(JOB_SLOTS)) ? JID_W'(1) : add_nxt[JID_W-1:0];

  // delete: largest remaining id plus one, saturating
  assign mx_d       = (rd_jid > mx_q) ? rd_jid : mx_q;
  assign mx_inc     = {1'b0, mx_d} + (JID_W+1)'(1);
  assign del_next_d = mx_inc[JID_W] ? JID_MAX : mx_inc[JID_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOB_SLOTS; i++) begin
        slot_pid_q[i] <= '0;
        slot_jid_q[i] <= '0;
        slot_st_q[i]  <= STATE_UNDEF;
      end
      next_q <= JID_W'(1);
    end else if (cmd_i.apply) begin
      unique case (op_q) inside
        OP_ADD: begin
          slot_pid_q[idx_q] <= key_pid_q;
          slot_jid_q[idx_q] <= next_q;
          slot_st_q[idx_q]  <= key_st_q;
          next_q            <= add_next_d;
        end
        OP_DEL_PID: begin
          slot_pid_q[idx_q] <= '0;
          slot_jid_q[idx_q] <= '0;
          slot_st_q[idx_q]  <= STATE_UNDEF;
        end
        OP_SET_PID, OP_SET_JID: begin
          slot_st_q[idx_q] <= key_st_q;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.max_done) begin
      next_q <= del_next_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      mx_q  <= '0;
    end else if (cmd_i.load || (cmd_i.apply && op_q == OP_DEL_PID)) begin
      idx_q <= '0;
      mx_q  <= '0;
    end else if (cmd_i.step || cmd_i.max_step) begin
      idx_q <= idx_q + SLOT_W'(1);
      if (cmd_i.max_step) begin
        mx_q <= mx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= in_op_i;
      key_pid_q <= in_pid_i;
      key_jid_q <= in_jid_i;
      key_st_q  <= in_st_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_hit_q <= 1'b0;
      res_pid_q <= '0;
      res_jid_q <= '0;
      res_st_q  <= '0;
    end else if (cmd_i.load) begin
      res_hit_q <= 1'b0;
      res_pid_q <= '0;
      res_jid_q <= '0;
      res_st_q  <= '0;
    end else if (cmd_i.apply) begin
      res_hit_q <= 1'b1;
      res_pid_q <= rd_pid;
      res_jid_q <= rd_jid;
      res_st_q  <= rd_st;
      unique case (op_q) inside
        OP_ADD: begin
          res_pid_q <= key_pid_q;
          res_jid_q <= next_q;
          res_st_q  <= key_st_q;
        end
        OP_DEL_PID: begin
          res_st_q <= STATE_UNDEF;
        end
        OP_SET_PID, OP_SET_JID: begin
          res_st_q <= key_st_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_hit_q <= 1'b0;
      out_pid_q <= '0;
      out_jid_q <= '0;
      out_st_q  <= '0;
    end else if (cmd_i.emit) begin
      out_hit_q <= res_hit_q;
      out_pid_q <= res_pid_q;
      out_jid_q <= res_jid_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_hit_o = out_hit_q;
  assign out_pid_o = out_pid_q;
  assign out_jid_o = out_jid_q;
  assign out_st_o  = out_st_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_hit_q |-> (out_pid_q == '0 && out_jid_q == '0 && out_st_q == '0))
    else $error("miss result carries nonzero fields");

  a_add_next_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_q == OP_ADD) |=>
      (next_q != '0 && next_q <= JID_W'(JOB_SLOTS)))
    else $error("next job id out of range after add");

  a_del_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && op_q == OP_DEL_PID) |=> (slot_pid_q[$past(idx_q)] == '0))
    else $error("deleted slot not freed");

endmodule

// ===== hw/rtl/jte_ctrl.sv =====
module jte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output jte_pkg::jte_cmd_t   cmd_o,
  input  jte_pkg::jte_stat_t  stat_i
);
  import jte_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat_i.key_ok) begin
          state_d = ST_EMIT;
        end else if (stat_i.match) begin
          cmd_o.apply = 1'b1;
          state_d     = stat_i.is_del ? ST_MAX : ST_EMIT;
        end else if (stat_i.last) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_MAX: begin
        if (stat_i.last) begin
          cmd_o.max_done = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.max_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_valid_q && !out_ready_i) |=>
      (state_q == ST_EMIT && out_valid_q))
    else $error("result overwrote an untaken result");

endmodule

// ===== hw/rtl/job_table_engine_top.sv =====
// Lookups, adds and sets go from request to result through ST_SCAN and ST_EMIT
// (slot-by-slot scan, first match wins); a delete adds ST_MAX, a max-id scan over all slots.
// One request in flight: a new request is taken only after the last result is emitted.
// A finished result waits in the output register while the next request is taken.
// Reset (async, active low) frees all slots at once and sets the next job id to 1.
module job_table_engine_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [jte_pkg::TDATA_W-1:0] s_axis_tdata,  // proc_id, job_key, new_state, zero pad
  input  logic [jte_pkg::OP_W-1:0]    s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [jte_pkg::TDATA_W-1:0] m_axis_tdata,  // out_pid, out_jid, out_state, zero pad
  output logic                        m_axis_tuser   // hit
);
  import jte_pkg::*;

  localparam int FIELDS_W = PID_W + JID_W + ST_W;

  jte_cmd_t         cmd;
  jte_stat_t        stat;
  logic [PID_W-1:0] out_pid;
  logic [JID_W-1:0] out_jid;
  logic [ST_W-1:0]  out_st;

  jte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  jte_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_op_i   (s_axis_tuser),
    .in_pid_i  (s_axis_tdata[PID_W-1:0]),
    .in_jid_i  (s_axis_tdata[PID_W+JID_W-1:PID_W]),
    .in_st_i   (s_axis_tdata[FIELDS_W-1:PID_W+JID_W]),
    .out_hit_o (m_axis_tuser),
    .out_pid_o (out_pid),
    .out_jid_o (out_jid),
    .out_st_o  (out_st)
  );

  assign m_axis_tdata = {{(TDATA_W-FIELDS_W){1'b0}}, out_st, out_jid, out_pid};

endmodule
